// File: sv/ubse_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ubse_pkg
// Shared types, constants and tables of the uniform B-spline evaluator.
// ----------------------------------------------------------------------------
package ubse_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int MAX_COEFFS  = 64;
   localparam int MAX_DEGREE  = 7;
   localparam int COEFF_W     = 24;
   localparam int X_W         = 21;
   localparam int ADDR_W      = 6;
   localparam int BASIS_W     = 18;
   localparam int WIN_SLOTS   = MAX_DEGREE + 1;

   // configuration register indexes
   localparam logic [1:0] CSR_GRID   = 2'd0;
   localparam logic [1:0] CSR_DEGREE = 2'd1;

   // datapath commands
   typedef enum logic [3:0] {
      OP_NOP   = 4'd0,
      OP_WRITE = 4'd1,
      OP_LATCH = 4'd2,
      OP_MUL_T = 4'd3,
      OP_CHECK = 4'd4,
      OP_MUL_A = 4'd5,
      OP_MUL_B = 4'd6,
      OP_MUL_R = 4'd7,
      OP_STORE = 4'd8,
      OP_READ  = 4'd9,
      OP_MAC   = 4'd10,
      OP_ADD   = 4'd11
   } ubse_op_type;

   typedef struct packed {
      ubse_op_type op;
      logic [2:0]  level;
      logic [2:0]  index;
   } ubse_cmd_type;

   typedef struct packed {
      logic       cfg_error;
      logic       range_ok;
      logic [2:0] order;
   } ubse_status_type;

   // ceil(2^26 / k): divide by the recursion level through one multiply
   function automatic logic [26:0] recip_of(input logic [2:0] k);
      logic [26:0] r;
      r = 27'd0;
      case (k)
         3'd1:    r = 27'd67108864;
         3'd2:    r = 27'd33554432;
         3'd3:    r = 27'd22369622;
         3'd4:    r = 27'd16777216;
         3'd5:    r = 27'd13421773;
         3'd6:    r = 27'd11184811;
         3'd7:    r = 27'd9586981;
         default: r = 27'd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// File: sv/ubse_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ubse_ctrl
// Sequencer: walks the recursion levels and the coefficient sum, issuing one
// datapath command per cycle.
// ----------------------------------------------------------------------------
module ubse_ctrl
   import ubse_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic            req_operation,
   input  wire ubse_status_type status,
   output ubse_cmd_type         cmd,
   output logic                 busy,
   output logic                 rsp_valid
);

   typedef enum logic [10:0] {
      ST_IDLE = 11'b00000000001,
      ST_MT   = 11'b00000000010,
      ST_CK   = 11'b00000000100,
      ST_MA   = 11'b00000001000,
      ST_MB   = 11'b00000010000,
      ST_MR   = 11'b00000100000,
      ST_MW   = 11'b00001000000,
      ST_AR   = 11'b00010000000,
      ST_AM   = 11'b00100000000,
      ST_AA   = 11'b01000000000,
      ST_OUT  = 11'b10000000000
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] level_ff, level_in;
   logic [2:0] index_ff, index_in;

   // next state and loop counters
   always_comb begin
      state_in = state_ff;
      level_in = level_ff;
      index_in = index_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start && req_operation) begin
               state_in = status.cfg_error ? ST_OUT : ST_MT;
            end
         end
         ST_MT: state_in = ST_CK;
         ST_CK: begin
            index_in = 3'd0;
            level_in = 3'd1;
            if (!status.range_ok) begin
               state_in = ST_OUT;
            end else if (status.order == 3'd0) begin
               state_in = ST_AR;
            end else begin
               state_in = ST_MA;
            end
         end
         ST_MA: state_in = ST_MB;
         ST_MB: state_in = ST_MR;
         ST_MR: state_in = ST_MW;
         ST_MW: begin
            state_in = ST_MA;
            if (index_ff == level_ff) begin
               index_in = 3'd0;
               if (level_ff == status.order) begin
                  state_in = ST_AR;
               end else begin
                  level_in = level_ff + 3'd1;
               end
            end else begin
               index_in = index_ff + 3'd1;
            end
         end
         ST_AR: state_in = ST_AM;
         ST_AM: state_in = ST_AA;
         ST_AA: begin
            if (index_ff == status.order) begin
               state_in = ST_OUT;
            end else begin
               index_in = index_ff + 3'd1;
               state_in = ST_AR;
            end
         end
         ST_OUT:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         level_ff <= 3'd0;
         index_ff <= 3'd0;
      end else begin
         state_ff <= state_in;
         level_ff <= level_in;
         index_ff <= index_in;
      end
   end

   // command decode
   always_comb begin
      cmd.level = level_ff;
      cmd.index = index_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.op = req_operation ? OP_LATCH : OP_WRITE;
            end else begin
               cmd.op = OP_NOP;
            end
         end
         ST_MT:   cmd.op = OP_MUL_T;
         ST_CK:   cmd.op = OP_CHECK;
         ST_MA:   cmd.op = OP_MUL_A;
         ST_MB:   cmd.op = OP_MUL_B;
         ST_MR:   cmd.op = OP_MUL_R;
         ST_MW:   cmd.op = OP_STORE;
         ST_AR:   cmd.op = OP_READ;
         ST_AM:   cmd.op = OP_MAC;
         ST_AA:   cmd.op = OP_ADD;
         default: cmd.op = OP_NOP;
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

endmodule
`default_nettype wire

// File: sv/ubse_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ubse_datapath
// Coefficient memory, configuration registers, basis window and the shared
// multiplier that serves scaling, recursion, division and accumulation.
// ----------------------------------------------------------------------------
module ubse_datapath
   import ubse_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire ubse_cmd_type              cmd,
   output ubse_status_type                status,
   input  wire logic        [ADDR_W-1:0]  req_coeff_index,
   input  wire logic signed [COEFF_W-1:0] req_coeff_value,
   input  wire logic signed [X_W-1:0]     req_sample_x,
   input  wire logic                      csr_valid,
   input  wire logic                      csr_ready,
   input  wire logic        [1:0]         csr_index,
   input  wire logic        [5:0]         csr_wdata,
   output logic signed      [COEFF_W-1:0] rsp_spline_value,
   output logic                           rsp_config_error
);

   logic [5:0]          grid_ff;
   logic [2:0]          degree_ff;
   logic [6:0]          n_coef;
   logic [6:0]          m_knots;
   logic                cfg_error;

   logic [COEFF_W-1:0]  mem [0:MAX_COEFFS-1];
   logic [COEFF_W-1:0]  coef_rd_ff;
   logic                coef_ok_ff;

   logic signed [X_W-1:0]   x_ff;
   logic [6:0]              s_ff;
   logic [FRAC_BITS-1:0]    frac_ff;
   logic                    err_ff;
   logic signed [27:0]      ma, mb;
   logic signed [55:0]      prod_in, prod_ff;
   logic [38:0]             num_ff;
   logic [45:0]             acc_ff;
   logic [BASIS_W-1:0]      q_ff [0:WIN_SLOTS-1];
   logic [BASIS_W-1:0]      q_in [0:WIN_SLOTS-1];
   logic [BASIS_W-1:0]      prev_ff;

   logic [18:0]  a_term;
   logic [19:0]  b_term;
   logic [39:0]  num_sum;
   logic [22:0]  v_quot;
   logic [27:0]  t_val;
   logic         t_ok;
   logic [8:0]   j_acc;
   logic         j_ok;
   logic [BASIS_W-1:0] w_new;
   logic [46:0]  r_sum;
   logic [30:0]  r_int;

   // configuration derived sizes
   assign n_coef    = {1'b0, grid_ff} + {4'b0, degree_ff} - 7'd1;
   assign m_knots   = n_coef + {4'b0, degree_ff};
   assign cfg_error = (grid_ff == 6'd0) && (degree_ff == 3'd0);

   // scaled sample and its unit interval
   assign t_val = prod_ff[27:0];
   assign t_ok  = !t_val[27] && (t_val[26:16] < {4'b0, m_knots});

   assign status.cfg_error = cfg_error;
   assign status.range_ok  = t_ok;
   assign status.order     = degree_ff;

   // recursion weights relative to the unit interval
   assign a_term  = {cmd.level - cmd.index, frac_ff};
   assign b_term  = {({1'b0, cmd.index} + 4'd1), 16'd0} - {4'b0, frac_ff};
   assign num_sum = {1'b0, num_ff} + prod_ff[39:0] + {21'd0, cmd.level, 16'd0} / 40'd2;
   assign v_quot  = num_sum[38:16];
   assign w_new   = prod_ff[43:26];

   // coefficient slot for the current term
   assign j_acc = {2'b0, s_ff} - {6'b0, degree_ff} + {6'b0, cmd.index};
   assign j_ok  = !j_acc[8] && (j_acc[7:0] < {1'b0, n_coef}) && (j_acc[7:6] == 2'b00);

   // shared multiplier operand select
   always_comb begin
      ma = 28'sd0;
      mb = 28'sd0;
      case (cmd.op)
         OP_MUL_T: begin
            ma = {{7{x_ff[X_W-1]}}, x_ff};
            mb = {21'd0, m_knots};
         end
         OP_MUL_A: begin
            ma = {9'd0, a_term};
            mb = {10'd0, prev_ff};
         end
         OP_MUL_B: begin
            ma = {8'd0, b_term};
            mb = {10'd0, q_ff[0]};
         end
         OP_MUL_R: begin
            ma = {5'd0, v_quot};
            mb = {1'b0, recip_of(cmd.level)};
         end
         OP_MAC: begin
            ma = coef_ok_ff ? {{4{coef_rd_ff[COEFF_W-1]}}, coef_rd_ff} : 28'sd0;
            mb = {10'd0, q_ff[0]};
         end
         default: begin
            ma = 28'sd0;
            mb = 28'sd0;
         end
      endcase
   end

   assign prod_in = ma * mb;

   // basis window: set on check; store/MAC shift down, store inserts at level
   always_comb begin
      for (int k = 0; k < WIN_SLOTS; k++) begin
         q_in[k] = q_ff[k];
      end
      case (cmd.op)
         OP_CHECK: begin
            for (int k = 0; k < WIN_SLOTS; k++) begin
               q_in[k] = '0;
            end
            q_in[0] = BASIS_W'(1 << FRAC_BITS);
         end
         OP_STORE, OP_MAC: begin
            for (int k = 0; k < WIN_SLOTS - 1; k++) begin
               q_in[k] = q_ff[k+1];
            end
            q_in[WIN_SLOTS-1] = '0;
            if (cmd.op == OP_STORE) begin
               q_in[cmd.level] = w_new;
            end
         end
         default: begin
            for (int k = 0; k < WIN_SLOTS; k++) begin
               q_in[k] = q_ff[k];
            end
         end
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff   <= 6'd5;
         degree_ff <= 3'd3;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_GRID) begin
            grid_ff <= csr_wdata;
         end else if (csr_index == CSR_DEGREE) begin
            degree_ff <= csr_wdata[2:0];
         end
      end
   end

   // coefficient memory
   always_ff @(posedge clock) begin
      if (cmd.op == OP_WRITE) begin
         mem[req_coeff_index] <= req_coeff_value;
      end
      if (cmd.op == OP_READ) begin
         coef_rd_ff <= mem[j_acc[ADDR_W-1:0]];
      end
   end

   // arithmetic registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      for (int k = 0; k < WIN_SLOTS; k++) begin
         q_ff[k] <= q_in[k];
      end
      case (cmd.op)
         OP_LATCH: begin
            x_ff   <= req_sample_x;
            acc_ff <= '0;
            err_ff <= cfg_error;
         end
         OP_CHECK: begin
            s_ff    <= t_val[22:16];
            frac_ff <= t_val[15:0];
            prev_ff <= '0;
         end
         OP_MUL_B: num_ff <= prod_ff[38:0];
         OP_STORE: prev_ff <= (cmd.index == cmd.level) ? '0 : q_ff[0];
         OP_READ:  coef_ok_ff <= j_ok;
         OP_ADD:   acc_ff <= acc_ff + prod_ff[45:0];
         default: begin
            prev_ff <= prev_ff;
         end
      endcase
   end

   // round half up and saturate
   assign r_sum = {acc_ff[45], acc_ff} + 47'd32768;
   assign r_int = r_sum[46:16];

   always_comb begin
      if (!r_int[30] && (r_int[29:23] != 7'd0)) begin
         rsp_spline_value = 24'sh7FFFFF;
      end else if (r_int[30] && (r_int[29:23] != 7'h7F)) begin
         rsp_spline_value = -24'sh800000;
      end else begin
         rsp_spline_value = r_int[23:0];
      end
   end

   assign rsp_config_error = err_ff;

endmodule
`default_nettype wire

// File: sv/uniform_b_spline_evaluator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uniform_b_spline_evaluator_core
// Evaluates a uniform-knot B-spline from a stored coefficient table.
//
//   channel   ports                               handshake
//   request   req_operation/coeff_*/sample_x      start && !busy
//   response  rsp_spline_value, rsp_config_error  rsp_valid, one cycle
//   config    csr_index, csr_wdata                csr_valid && csr_ready
//
// A coefficient write leaves busy low. An evaluation with degree d runs
// as four steps per basis value and three per coefficient term, all
// sequenced around the single multiplier. A sample outside [0,1), or a
// zero grid with zero degree, ends the evaluation early.
// Reset is synchronous; the coefficient memory is not cleared. The response
// cannot be stalled.
// ----------------------------------------------------------------------------
module uniform_b_spline_evaluator_core
   import ubse_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic                      req_operation,
   input  wire logic        [ADDR_W-1:0]  req_coeff_index,
   input  wire logic signed [COEFF_W-1:0] req_coeff_value,
   input  wire logic signed [X_W-1:0]     req_sample_x,
   output logic                           rsp_valid,
   output logic signed      [COEFF_W-1:0] rsp_spline_value,
   output logic                           rsp_config_error,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic        [1:0]         csr_index,
   input  wire logic        [5:0]         csr_wdata
);

   ubse_cmd_type    cmd;
   ubse_status_type status;

   // registers take writes every cycle
   assign csr_ready = 1'b1;

   ubse_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_operation),
      .status        (status),
      .cmd           (cmd),
      .busy          (busy),
      .rsp_valid     (rsp_valid)
   );

   ubse_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_coeff_index  (req_coeff_index),
      .req_coeff_value  (req_coeff_value),
      .req_sample_x     (req_sample_x),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_spline_value (rsp_spline_value),
      .rsp_config_error (rsp_config_error)
   );

endmodule
`default_nettype wire

// File: sv/ubse_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ubse_checker
// Port-level checks of the spline evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module ubse_checker
   import ubse_pkg::*;
(
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      start,
   input wire logic                      busy,
   input wire logic                      req_operation,
   input wire logic                      rsp_valid,
   input wire logic signed [COEFF_W-1:0] rsp_spline_value,
   input wire logic                      rsp_config_error
);

   // a response is a single-cycle strobe
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held longer than one cycle");

   // a response only ends a running transaction
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response while idle");

   // an evaluation occupies the block
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation) |=> busy)
      else $error("evaluation did not raise busy");

   // a coefficient write completes at once
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_operation) |=> !busy)
      else $error("coefficient write raised busy");

   // bad configuration returns zero
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_config_error) |-> (rsp_spline_value == 24'sd0))
      else $error("configuration error with nonzero value");

endmodule

bind uniform_b_spline_evaluator_core ubse_checker u_ubse_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_operation    (req_operation),
   .rsp_valid        (rsp_valid),
   .rsp_spline_value (rsp_spline_value),
   .rsp_config_error (rsp_config_error)
);
`default_nettype wire
